### hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg: shared definitions for the framebuffer pixel access unit
// Register indexes, reset values, access codes and color conversion helpers.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_BASE_ADDRESS   = 3'd0;
  localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd1;
  localparam logic [2:0] REG_SCREEN_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_LINE_PITCH     = 3'd3;
  localparam logic [2:0] REG_BITS_PER_PIXEL = 3'd4;
  localparam logic [2:0] REG_RED_FIRST      = 3'd5;

  // Register reset values
  localparam logic [31:0] RST_BASE_ADDRESS   = 32'd0;
  localparam logic [13:0] RST_SCREEN_WIDTH   = 14'd1024;
  localparam logic [13:0] RST_SCREEN_HEIGHT  = 14'd768;
  localparam logic [15:0] RST_LINE_PITCH     = 16'd2048;
  localparam logic [5:0]  RST_BITS_PER_PIXEL = 6'd16;
  localparam logic        RST_RED_FIRST      = 1'b1;

  // Access codes
  localparam logic [1:0] FUNC_WRITE      = 2'd0;
  localparam logic [1:0] FUNC_READ_REQ   = 2'd1;
  localparam logic [1:0] FUNC_READ_RET   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED     = 2'd3;

  // Supported depths and their byte counts
  localparam logic [5:0] BPP_16 = 6'd16;
  localparam logic [5:0] BPP_24 = 6'd24;
  localparam logic [5:0] BPP_32 = 6'd32;
  localparam logic [2:0] BYTES_NONE = 3'd0;
  localparam logic [2:0] BYTES_16   = 3'd2;
  localparam logic [2:0] BYTES_24   = 3'd3;
  localparam logic [2:0] BYTES_32   = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Expand a 5-bit channel to 8 bits: (v*527+23)>>6
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [14:0] p;
    begin
      p = 15'({10'd0, v} * 15'd527) + 15'd23;
      expand5 = p[13:6];
    end
  endfunction

  // Expand a 6-bit channel to 8 bits: (v*259+33)>>6
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [14:0] p;
    begin
      p = 15'({9'd0, v} * 15'd259) + 15'd33;
      expand6 = p[13:6];
    end
  endfunction

  // Reduce 8 bits to 5: (v*31+127)/255, divide by reciprocal with correction
  function automatic logic [4:0] reduce5(input logic [7:0] v);
    logic [15:0] n;
    logic [15:0] q;
    begin
      n = 16'({8'd0, v} * 16'd31) + 16'd127;
      q = n + (n >> 8) + 16'd1;
      reduce5 = q[12:8];
    end
  endfunction

  // Reduce 8 bits to 6: (v*63+127)/255
  function automatic logic [5:0] reduce6(input logic [7:0] v);
    logic [15:0] n;
    logic [15:0] q;
    begin
      n = 16'({8'd0, v} * 16'd63) + 16'd127;
      q = n + (n >> 8) + 16'd1;
      reduce6 = q[13:8];
    end
  endfunction

endpackage

### hw/rtl/framebuffer_pixel_access_unit.sv
// ----------------------------------------------------------------------------
// framebuffer_pixel_access_unit
// Clips a pixel access, forms its byte address and converts RGB565 colors
// to and from the native 16, 24 or 32 bpp pixel word.
// ----------------------------------------------------------------------------
// One request enters per clock while in_ready is high and moves through the
// stages (clip and depth decode, then the line multiply and color conversion,
// then the address add into the output register). Each stage holds its own
// valid bit and loads when it is empty or its successor moves, so a stalled
// output keeps the pipe filling until all three stages hold a request. The
// configuration port always takes writes (cfg_ready is tied high); write it
// only while no request is in flight.
module framebuffer_pixel_access_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // pixel requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [15:0] x_pos,
  input  logic [15:0] y_pos,
  input  logic [15:0] color_in,
  input  logic [31:0] fetched_word,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] byte_address,
  output logic [31:0] write_data,
  output logic [2:0]  byte_count,
  output logic [15:0] color_out
);

  // Configuration registers
  logic [31:0] base_address;
  logic [13:0] screen_width;
  logic [13:0] screen_height;
  logic [15:0] line_pitch;
  logic [5:0]  bits_per_pixel;
  logic        red_first;

  assign cfg_ready = 1'b1;

  // Write the addressed register; other indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= fbpa_pkg::RST_BASE_ADDRESS;
      screen_width   <= fbpa_pkg::RST_SCREEN_WIDTH;
      screen_height  <= fbpa_pkg::RST_SCREEN_HEIGHT;
      line_pitch     <= fbpa_pkg::RST_LINE_PITCH;
      bits_per_pixel <= fbpa_pkg::RST_BITS_PER_PIXEL;
      red_first      <= fbpa_pkg::RST_RED_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbpa_pkg::REG_BASE_ADDRESS:   base_address   <= cfg_data;
        fbpa_pkg::REG_SCREEN_WIDTH:   screen_width   <= cfg_data[13:0];
        fbpa_pkg::REG_SCREEN_HEIGHT:  screen_height  <= cfg_data[13:0];
        fbpa_pkg::REG_LINE_PITCH:     line_pitch     <= cfg_data[15:0];
        fbpa_pkg::REG_BITS_PER_PIXEL: bits_per_pixel <= cfg_data[5:0];
        fbpa_pkg::REG_RED_FIRST:      red_first      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage load enables: a stage loads when empty or when its successor loads
  logic s1_valid, s2_valid;
  logic out_load, s2_load, s1_load;

  assign out_load = !out_valid || out_ready;
  assign s2_load  = !s2_valid || out_load;
  assign s1_load  = !s1_valid || s2_load;
  assign in_ready = s1_load;

  // ---------------- Stage 1: depth decode and clipping ----------------
  logic [2:0] s1_bytes_next;
  logic       s1_hit_next;

  always_comb begin
    case (bits_per_pixel)
      fbpa_pkg::BPP_16: s1_bytes_next = fbpa_pkg::BYTES_16;
      fbpa_pkg::BPP_24: s1_bytes_next = fbpa_pkg::BYTES_24;
      fbpa_pkg::BPP_32: s1_bytes_next = fbpa_pkg::BYTES_32;
      default:          s1_bytes_next = fbpa_pkg::BYTES_NONE;
    endcase
    s1_hit_next = (s1_bytes_next != fbpa_pkg::BYTES_NONE) &&
                  (func != fbpa_pkg::FUNC_UNUSED) &&
                  !x_pos[15] && !y_pos[15] &&
                  (x_pos[14:0] < {1'b0, screen_width}) &&
                  (y_pos[14:0] < {1'b0, screen_height});
  end

  logic        s1_hit;
  logic [2:0]  s1_bytes;
  logic [1:0]  s1_func;
  logic [14:0] s1_x;
  logic [14:0] s1_y;
  logic [15:0] s1_color;
  logic [23:0] s1_fetched;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_hit     <= s1_hit_next;
      s1_bytes   <= s1_bytes_next;
      s1_func    <= func;
      s1_x       <= x_pos[14:0];
      s1_y       <= y_pos[14:0];
      s1_color   <= color_in;
      s1_fetched <= fetched_word[23:0];
    end
  end

  // ---------------- Stage 2: line multiply and color conversion ----------------
  logic [30:0] s2_yprod_next;
  logic [16:0] s2_xoff_next;
  logic [7:0]  exp_r, exp_g, exp_b;
  logic [23:0] native;
  logic [7:0]  ret_r, ret_b;
  logic [15:0] rgb565;
  logic [31:0] s2_wdata_next;
  logic [15:0] s2_cout_next;

  always_comb begin
    s2_yprod_next = 31'({16'd0, s1_y} * {15'd0, line_pitch});
    case (s1_bytes)
      fbpa_pkg::BYTES_16: s2_xoff_next = {1'b0, s1_x, 1'b0};
      fbpa_pkg::BYTES_24: s2_xoff_next = {1'b0, s1_x, 1'b0} + {2'b0, s1_x};
      fbpa_pkg::BYTES_32: s2_xoff_next = {s1_x, 2'b0};
      default:            s2_xoff_next = '0;
    endcase

    // Expand RGB565 to the native byte order
    exp_r  = fbpa_pkg::expand5(s1_color[15:11]);
    exp_g  = fbpa_pkg::expand6(s1_color[10:5]);
    exp_b  = fbpa_pkg::expand5(s1_color[4:0]);
    native = red_first ? {exp_b, exp_g, exp_r} : {exp_r, exp_g, exp_b};

    // Reduce the fetched native word to RGB565
    ret_r  = red_first ? s1_fetched[7:0]   : s1_fetched[23:16];
    ret_b  = red_first ? s1_fetched[23:16] : s1_fetched[7:0];
    rgb565 = {fbpa_pkg::reduce5(ret_r), fbpa_pkg::reduce6(s1_fetched[15:8]),
              fbpa_pkg::reduce5(ret_b)};

    s2_wdata_next = '0;
    s2_cout_next  = '0;
    if (s1_func == fbpa_pkg::FUNC_WRITE) begin
      case (s1_bytes)
        fbpa_pkg::BYTES_16: s2_wdata_next = {16'd0, s1_color};
        fbpa_pkg::BYTES_24: s2_wdata_next = {8'd0, native};
        fbpa_pkg::BYTES_32: s2_wdata_next = {fbpa_pkg::ALPHA_OPAQUE, native};
        default:            s2_wdata_next = '0;
      endcase
    end else if (s1_func == fbpa_pkg::FUNC_READ_RET) begin
      s2_cout_next = (s1_bytes == fbpa_pkg::BYTES_16) ? s1_fetched[15:0] : rgb565;
    end
  end

  logic        s2_hit;
  logic [2:0]  s2_bytes;
  logic [30:0] s2_yprod;
  logic [16:0] s2_xoff;
  logic [31:0] s2_wdata;
  logic [15:0] s2_cout;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_hit   <= s1_hit;
      s2_bytes <= s1_bytes;
      s2_yprod <= s2_yprod_next;
      s2_xoff  <= s2_xoff_next;
      s2_wdata <= s2_wdata_next;
      s2_cout  <= s2_cout_next;
    end
  end

  // ---------------- Stage 3: address add, zero on miss ----------------
  logic [31:0] addr_next;

  assign addr_next = base_address + {1'b0, s2_yprod} + {15'd0, s2_xoff};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit          <= s2_hit;
      byte_address <= s2_hit ? addr_next : '0;
      write_data   <= s2_hit ? s2_wdata  : '0;
      byte_count   <= s2_hit ? s2_bytes  : fbpa_pkg::BYTES_NONE;
      color_out    <= s2_hit ? s2_cout   : '0;
    end
  end

  // ---------------- Assertions ----------------
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> byte_address == '0 && write_data == '0 &&
                          byte_count == fbpa_pkg::BYTES_NONE && color_out == '0)
    else $error("miss result carries nonzero fields");

  a_hit_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> byte_count == fbpa_pkg::BYTES_16 ||
                         byte_count == fbpa_pkg::BYTES_24 ||
                         byte_count == fbpa_pkg::BYTES_32)
    else $error("hit result with unsupported byte count");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s2_valid && out_valid && !out_ready)
    else $error("input stalled while pipeline has room");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid && !s2_valid)
    else $error("pipeline not empty after reset");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for framebuffer_pixel_access_unit
// Drives pixel requests through the valid/ready request channel under random
// sender bursts and receiver stalls, predicts every result from a local copy
// of the configuration registers, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_SLACK  = 6;
  localparam int QUIET_LIMIT = 400;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic        hit;
    logic [31:0] byte_address;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
    logic [15:0] color_out;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = fbpa_pkg::REG_BASE_ADDRESS;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = fbpa_pkg::FUNC_WRITE;
  logic [15:0] x_pos = '0;
  logic [15:0] y_pos = '0;
  logic [15:0] color_in = '0;
  logic [31:0] fetched_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [31:0] byte_address;
  logic [31:0] write_data;
  logic [2:0]  byte_count;
  logic [15:0] color_out;

  // Local copy of the configuration registers
  logic [31:0] fb_base      = fbpa_pkg::RST_BASE_ADDRESS;
  logic [13:0] fb_width     = fbpa_pkg::RST_SCREEN_WIDTH;
  logic [13:0] fb_height    = fbpa_pkg::RST_SCREEN_HEIGHT;
  logic [15:0] fb_pitch     = fbpa_pkg::RST_LINE_PITCH;
  logic [5:0]  fb_bpp       = fbpa_pkg::RST_BITS_PER_PIXEL;
  logic        fb_red_first = fbpa_pkg::RST_RED_FIRST;

  pixel_result_t pending_results[$];
  int mismatches  = 0;
  int burst_left  = 0;
  int quiet_count = 0;
  int stall_mode  = 0;
  int stall_left  = 0;
  int stalled_run = 0;

  framebuffer_pixel_access_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .color_in     (color_in),
    .fetched_word (fetched_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .byte_address (byte_address),
    .write_data   (write_data),
    .byte_count   (byte_count),
    .color_out    (color_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scale a 5- or 6-bit channel up to 8 bits
  function automatic logic [7:0] widen_channel(input int unsigned v, input int unsigned mult,
                                               input int unsigned bias);
    return 8'((v * mult + bias) >> 6);
  endfunction

  // Scale an 8-bit channel down to a top value of 31 or 63, rounded
  function automatic logic [7:0] narrow_channel(input logic [7:0] v, input int unsigned top);
    return 8'((32'(v) * top + 32'd127) / 32'd255);
  endfunction

  // Work out the result of one pixel request under the current registers
  function automatic pixel_result_t predict_access(input logic [1:0] f,
                                                   input logic [15:0] x, y, c,
                                                   input logic [31:0] w);
    pixel_result_t r;
    logic [2:0]  nbytes;
    logic [7:0]  red8, green8, blue8, low8, high8;
    logic [31:0] native;
    r = '0;
    case (fb_bpp)
      fbpa_pkg::BPP_16: nbytes = fbpa_pkg::BYTES_16;
      fbpa_pkg::BPP_24: nbytes = fbpa_pkg::BYTES_24;
      fbpa_pkg::BPP_32: nbytes = fbpa_pkg::BYTES_32;
      default:          nbytes = fbpa_pkg::BYTES_NONE;
    endcase
    // Clip: bad depth, unused code, negative or past the edge all miss
    if (nbytes == fbpa_pkg::BYTES_NONE || f == fbpa_pkg::FUNC_UNUSED || x[15] || y[15] ||
        x >= {2'b00, fb_width} || y >= {2'b00, fb_height})
      return r;
    r.hit = 1'b1;
    r.byte_count = nbytes;
    r.byte_address = fb_base + {16'd0, y} * {16'd0, fb_pitch} + {16'd0, x} * {29'd0, nbytes};
    if (f == fbpa_pkg::FUNC_WRITE) begin
      red8   = widen_channel(32'(c[15:11]), 527, 23);
      green8 = widen_channel(32'(c[10:5]), 259, 33);
      blue8  = widen_channel(32'(c[4:0]), 527, 23);
      low8   = fb_red_first ? red8 : blue8;
      high8  = fb_red_first ? blue8 : red8;
      native = {fbpa_pkg::ALPHA_OPAQUE, high8, green8, low8};
      case (nbytes)
        fbpa_pkg::BYTES_16: r.write_data = {16'd0, c};
        fbpa_pkg::BYTES_24: r.write_data = {8'd0, native[23:0]};
        default:            r.write_data = native;
      endcase
    end else if (f == fbpa_pkg::FUNC_READ_RET) begin
      if (nbytes == fbpa_pkg::BYTES_16) begin
        r.color_out = w[15:0];
      end else begin
        low8   = w[7:0];
        high8  = w[23:16];
        red8   = narrow_channel(fb_red_first ? low8 : high8, 31);
        green8 = narrow_channel(w[15:8], 63);
        blue8  = narrow_channel(fb_red_first ? high8 : low8, 31);
        r.color_out = {red8[4:0], green8[5:0], blue8[4:0]};
      end
    end
    return r;
  endfunction

  // Write one register and mirror it into the local copy
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fbpa_pkg::REG_BASE_ADDRESS:   fb_base      = data;
      fbpa_pkg::REG_SCREEN_WIDTH:   fb_width     = data[13:0];
      fbpa_pkg::REG_SCREEN_HEIGHT:  fb_height    = data[13:0];
      fbpa_pkg::REG_LINE_PITCH:     fb_pitch     = data[15:0];
      fbpa_pkg::REG_BITS_PER_PIXEL: fb_bpp       = data[5:0];
      fbpa_pkg::REG_RED_FIRST:      fb_red_first = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Load every register; junk above each field width must be dropped
  task automatic apply_config(input logic [31:0] base, input logic [13:0] width,
                              input logic [13:0] height, input logic [15:0] pitch,
                              input logic [5:0] bpp, input logic red_first);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(fbpa_pkg::REG_BASE_ADDRESS, base);
    write_reg(fbpa_pkg::REG_SCREEN_WIDTH, {junk[31:14], width});
    write_reg(fbpa_pkg::REG_SCREEN_HEIGHT, {junk[17:0], height});
    write_reg(fbpa_pkg::REG_LINE_PITCH, {junk[15:0], pitch});
    write_reg(fbpa_pkg::REG_BITS_PER_PIXEL, {junk[25:0], bpp});
    write_reg(fbpa_pkg::REG_RED_FIRST, {junk[30:0], red_first});
  endtask

  // Send one pixel request, in bursts with random gaps between them
  task automatic send_access(input logic [1:0] f, input logic [15:0] x, y, c,
                             input logic [31:0] w);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(32, 96);
      end else begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 6);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    x_pos        <= x;
    y_pos        <= y;
    color_in     <= c;
    fetched_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_access(f, x, y, c, w));
    burst_left--;
  endtask

  // Drop valid and let every outstanding request come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Coordinate mostly on screen, some on the edge, some anywhere
  function automatic logic [15:0] pick_coord(input int unsigned limit);
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 7) return 16'($urandom_range(0, limit - 1));
    if (k == 7) return 16'(limit - 1 + $urandom_range(0, 2));
    return 16'($urandom);
  endfunction

  task automatic test_reset_defaults();
    send_access(fbpa_pkg::FUNC_WRITE, 16'd0, 16'd0, 16'hFFFF, 32'h0);
    send_access(fbpa_pkg::FUNC_READ_REQ, 16'd1023, 16'd767, 16'h1234, 32'h0);
    send_access(fbpa_pkg::FUNC_READ_RET, 16'd5, 16'd5, 16'h0, 32'hDEADBEEF);
    send_access(fbpa_pkg::FUNC_WRITE, 16'd1024, 16'd0, 16'hA5A5, 32'h0);
    send_access(fbpa_pkg::FUNC_READ_REQ, 16'd0, 16'd768, 16'h0, 32'h0);
    send_access(fbpa_pkg::FUNC_WRITE, 16'hFFFF, 16'd3, 16'h5555, 32'h0);
    send_access(fbpa_pkg::FUNC_READ_REQ, 16'd3, 16'h8000, 16'h0, 32'h0);
    send_access(fbpa_pkg::FUNC_UNUSED, 16'd1, 16'd1, 16'hFFFF, 32'hFFFFFFFF);
    send_access(fbpa_pkg::FUNC_READ_RET, 16'h7FFF, 16'd0, 16'h0, 32'h12345678);
    wait_for_results();
  endtask

  task automatic test_large_screen_wrap();
    apply_config(32'hFFFFFFF0, 14'd8192, 14'd8192, 16'hFFFF, fbpa_pkg::BPP_32, 1'b1);
    send_access(fbpa_pkg::FUNC_WRITE, 16'd8191, 16'd8191, 16'hF800, 32'h0);
    send_access(fbpa_pkg::FUNC_READ_RET, 16'd1, 16'd2, 16'h0, 32'hAAFF8040);
    send_access(fbpa_pkg::FUNC_WRITE, 16'd0, 16'd0, 16'h07E0, 32'h0);
    wait_for_results();
    apply_config(32'h1000_0000, 14'd8192, 14'd8192, 16'd12288, fbpa_pkg::BPP_24, 1'b0);
    send_access(fbpa_pkg::FUNC_WRITE, 16'd3, 16'd1, 16'h001F, 32'h0);
    send_access(fbpa_pkg::FUNC_READ_RET, 16'd8191, 16'd0, 16'h0, 32'hFF123456);
    send_access(fbpa_pkg::FUNC_READ_REQ, 16'd2, 16'd3, 16'hFFFF, 32'hFFFFFFFF);
    wait_for_results();
  endtask

  task automatic test_unsupported_depth();
    apply_config(32'h0, 14'd640, 14'd480, 16'd2560, 6'd0, 1'b1);
    send_access(fbpa_pkg::FUNC_WRITE, 16'd0, 16'd0, 16'hFFFF, 32'h0);
    wait_for_results();
    apply_config(32'h0, 14'd640, 14'd480, 16'd2560, 6'd63, 1'b1);
    send_access(fbpa_pkg::FUNC_READ_RET, 16'd0, 16'd0, 16'h0, 32'hFFFFFFFF);
    wait_for_results();
  endtask

  task automatic test_degenerate_screen();
    apply_config(32'h0, 14'd0, 14'd1, 16'd1, fbpa_pkg::BPP_16, 1'b1);
    send_access(fbpa_pkg::FUNC_READ_REQ, 16'd0, 16'd0, 16'h0, 32'h0);
    wait_for_results();
    apply_config(32'h0, 14'd1, 14'd0, 16'd1, fbpa_pkg::BPP_16, 1'b1);
    send_access(fbpa_pkg::FUNC_WRITE, 16'd0, 16'd0, 16'h1234, 32'h0);
    wait_for_results();
    apply_config(32'h0, 14'd1, 14'd1, 16'd1, fbpa_pkg::BPP_16, 1'b1);
    send_access(fbpa_pkg::FUNC_WRITE, 16'd0, 16'd0, 16'h1234, 32'h0);
    send_access(fbpa_pkg::FUNC_READ_REQ, 16'd1, 16'd0, 16'h0, 32'h0);
    send_access(fbpa_pkg::FUNC_READ_RET, 16'd0, 16'd0, 16'h0, 32'h12345678);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int          phase, n;
    int unsigned sel;
    logic [13:0] width, height;
    logic [5:0]  bpp;
    logic [1:0]  f;
    for (phase = 0; phase < 8; phase++) begin
      // Pick a configuration: the two extremes first, then random ones
      case (phase)
        0: apply_config(32'hFFFFFFFF, 14'd8192, 14'd8192, 16'hFFFF, fbpa_pkg::BPP_32, 1'b1);
        1: apply_config(32'h0, 14'd1, 14'd1, 16'd1, fbpa_pkg::BPP_24, 1'b0);
        default: begin
          width  = $urandom_range(0, 1) ? 14'($urandom_range(1, 64))
                                        : 14'($urandom_range(1, 8192));
          height = $urandom_range(0, 1) ? 14'($urandom_range(1, 64))
                                        : 14'($urandom_range(1, 8192));
          sel = $urandom_range(0, 9);
          if (sel < 3)      bpp = fbpa_pkg::BPP_16;
          else if (sel < 6) bpp = fbpa_pkg::BPP_24;
          else if (sel < 9) bpp = fbpa_pkg::BPP_32;
          else              bpp = 6'($urandom_range(0, 63));
          apply_config($urandom, width, height, 16'($urandom_range(1, 65535)), bpp,
                       1'($urandom_range(0, 1)));
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 15);
        if (sel < 5)       f = fbpa_pkg::FUNC_WRITE;
        else if (sel < 10) f = fbpa_pkg::FUNC_READ_REQ;
        else if (sel < 15) f = fbpa_pkg::FUNC_READ_RET;
        else               f = fbpa_pkg::FUNC_UNUSED;
        send_access(f, pick_coord(32'(fb_width)), pick_coord(32'(fb_height)),
                    16'($urandom), $urandom);
      end
      wait_for_results();
    end
  endtask

  // Stall the result side in modes: always ready, coin flip, sparse, toggling
  always @(posedge clk) begin : result_stall
    logic take;
    case (stall_mode)
      0:       take = 1'b1;
      1:       take = 1'($urandom_range(0, 1));
      2:       take = ($urandom_range(0, 3) == 0);
      default: take = ~out_ready;
    endcase
    if (stalled_run >= 8) take = 1'b1;
    out_ready   <= take;
    stalled_run <= take ? 0 : stalled_run + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding, actual hit %0b addr %0h",
                 $time, hit, byte_address);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        report_field("hit", 32'(want.hit), 32'(hit));
        report_field("byte_address", want.byte_address, byte_address);
        report_field("write_data", want.write_data, write_data);
        report_field("byte_count", 32'(want.byte_count), 32'(byte_count));
        report_field("color_out", 32'(want.color_out), 32'(color_out));
      end
    end
  end

  // End the run when no handshake completes for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count >= QUIET_LIMIT) begin
      $display("framebuffer_pixel_access_unit: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_large_screen_wrap();
    test_unsupported_depth();
    test_degenerate_screen();
    test_random_traffic();
    if (mismatches == 0)
      $display("framebuffer_pixel_access_unit: match");
    else
      $display("framebuffer_pixel_access_unit: mismatch");
    $finish;
  end

endmodule
